@@ hdl/aarm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared constants and types for the axis-angle rotation matrix pipeline.
// ----------------------------------------------------------------------------
package aarm_pkg;

  localparam int unsigned AARM_FRAC_BITS  = 30;
  localparam int unsigned AARM_ANGLE_BITS = 32;

  localparam logic [63:0] PI4_Q62 = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
  localparam logic [63:0] ONE_Q61 = 64'h2000000000000000;

  localparam int unsigned TAYLOR_STEPS = 13;
  localparam int unsigned STEP_STAGES  = 5;
  // angle reduce (1), x multiply (2), x^2 multiply (2)
  localparam int unsigned STEP_BASE    = 5;
  localparam int unsigned FIN_BASE     = STEP_BASE + STEP_STAGES * TAYLOR_STEPS;
  localparam int unsigned TRIG_STAGES  = FIN_BASE + 3;
  localparam int unsigned MAT_STAGES   = 7;

  // Values that ride alongside the series terms
  typedef struct packed {
    logic [63:0] ss;
    logic [63:0] cs;
    logic [63:0] x2;
    logic [2:0]  k;
  } aarm_carry_t;

endpackage

@@ hdl/aarm_pipe_ctl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_pipe_ctl
// Stage valid bits and per-stage load enables; bubbles collapse under stall.
// ----------------------------------------------------------------------------
module aarm_pipe_ctl #(
  parameter int unsigned STAGES = 80
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [STAGES-1:0] en_o
);

  logic [STAGES-1:0] v_q;
  logic [STAGES-1:0] v_d;

  assign v_d = {v_q[STAGES-2:0], valid_i};

  // a stage may load unless it and everything after it is full and held
  for (genvar k = 0; k < STAGES; k++) begin : g_en
    assign en_o[k] = ~((&v_q[STAGES-1:k]) & stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (en_o[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign stall_o = ~en_o[0];
  assign valid_o = v_q[STAGES-1];

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o)
    else $error("held result dropped");
  a_empty_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o)
    else $error("input stalled with empty output stage");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> v_q[0])
    else $error("accepted request not captured");
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_i |-> (&en_o))
    else $error("stage frozen without downstream stall");
`endif

endmodule

@@ hdl/aarm_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_mul
// 64x64 unsigned multiply over two stages, with optional rounding shift.
// ----------------------------------------------------------------------------
module aarm_mul #(
  parameter int unsigned SHIFT = 62,
  parameter bit          ROUND = 1'b1
) (
  input  logic        clk_i,
  input  logic [1:0]  en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  localparam logic [127:0] RND = (ROUND && (SHIFT > 0)) ? (128'd1 << (SHIFT - 1)) : 128'd0;

  logic [63:0]  pp00_q, pp01_q, pp10_q, pp11_q;
  logic [127:0] sum;
  logic [63:0]  p_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pp00_q <= 64'(a_i[31:0])  * 64'(b_i[31:0]);
      pp01_q <= 64'(a_i[31:0])  * 64'(b_i[63:32]);
      pp10_q <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
      pp11_q <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
    end
  end

  assign sum = {64'd0, pp00_q} + {32'd0, pp01_q, 32'd0} + {32'd0, pp10_q, 32'd0}
             + {pp11_q, 64'd0} + RND;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_q <= 64'(sum >> SHIFT);
    end
  end

  assign p_o = p_q;

endmodule

@@ hdl/aarm_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_step
// One sine/cosine series step: term*x^2, divide by constant, accumulate.
// ----------------------------------------------------------------------------
module aarm_step #(
  parameter int unsigned J = 1
) (
  input  logic                 clk_i,
  input  logic [4:0]           en_i,
  input  logic [63:0]          st_i,
  input  logic [63:0]          ct_i,
  input  aarm_pkg::aarm_carry_t carry_i,
  output logic [63:0]          st_o,
  output logic [63:0]          ct_o,
  output aarm_pkg::aarm_carry_t carry_o
);
  import aarm_pkg::*;

  localparam logic [63:0] DIV_S = 64'((2 * J) * (2 * J + 1));
  localparam logic [63:0] DIV_C = 64'((2 * J - 1) * (2 * J));
  localparam logic [63:0] RCP_S = ONE_Q62 / DIV_S;
  localparam logic [63:0] RCP_C = ONE_Q62 / DIV_C;
  localparam bit          PREV_ODD = ((J - 1) % 2) == 1;

  aarm_carry_t carry_q [0:4];
  aarm_carry_t carry_d;
  logic [63:0] n_s, n_c, q0_s, q0_c;
  logic [63:0] ns2_q, nc2_q, ns3_q, nc3_q;
  logic [63:0] rem_s, rem_c, q_s, q_c;
  logic [63:0] st_q, ct_q;

  // fold in the previous step's term
  always_comb begin
    carry_d = carry_i;
    if (J > 1) begin
      if (PREV_ODD) begin
        carry_d.ss = carry_i.ss - st_i;
        carry_d.cs = carry_i.cs - ct_i;
      end else begin
        carry_d.ss = carry_i.ss + st_i;
        carry_d.cs = carry_i.cs + ct_i;
      end
    end
  end

  aarm_mul #(.SHIFT(62), .ROUND(1'b1)) u_mul_s (
    .clk_i(clk_i), .en_i(en_i[1:0]), .a_i(st_i), .b_i(carry_i.x2), .p_o(n_s));
  aarm_mul #(.SHIFT(62), .ROUND(1'b1)) u_mul_c (
    .clk_i(clk_i), .en_i(en_i[1:0]), .a_i(ct_i), .b_i(carry_i.x2), .p_o(n_c));

  // reciprocal estimate, low by at most one
  aarm_mul #(.SHIFT(62), .ROUND(1'b0)) u_rcp_s (
    .clk_i(clk_i), .en_i(en_i[3:2]), .a_i(n_s), .b_i(RCP_S), .p_o(q0_s));
  aarm_mul #(.SHIFT(62), .ROUND(1'b0)) u_rcp_c (
    .clk_i(clk_i), .en_i(en_i[3:2]), .a_i(n_c), .b_i(RCP_C), .p_o(q0_c));

  assign rem_s = ns3_q - 64'(q0_s * DIV_S);
  assign rem_c = nc3_q - 64'(q0_c * DIV_C);
  assign q_s   = q0_s + 64'(rem_s >= DIV_S);
  assign q_c   = q0_c + 64'(rem_c >= DIV_C);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) carry_q[0] <= carry_d;
    if (en_i[1]) carry_q[1] <= carry_q[0];
    if (en_i[2]) begin
      carry_q[2] <= carry_q[1];
      ns2_q      <= n_s;
      nc2_q      <= n_c;
    end
    if (en_i[3]) begin
      carry_q[3] <= carry_q[2];
      ns3_q      <= ns2_q;
      nc3_q      <= nc2_q;
    end
    if (en_i[4]) begin
      carry_q[4] <= carry_q[3];
      st_q       <= q_s;
      ct_q       <= q_c;
    end
  end

  assign st_o    = st_q;
  assign ct_o    = ct_q;
  assign carry_o = carry_q[4];

endmodule

@@ hdl/aarm_trig.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_trig
// Binary angle to cosine and sine in Q61, octant reduction plus series.
// ----------------------------------------------------------------------------
module aarm_trig #(
  parameter int unsigned ANGLE_BITS = aarm_pkg::AARM_ANGLE_BITS
) (
  input  logic                               clk_i,
  input  logic [aarm_pkg::TRIG_STAGES-1:0]   en_i,
  input  logic [31:0]                        angle_i,
  output logic signed [63:0]                 c_o,
  output logic signed [63:0]                 s_o
);
  import aarm_pkg::*;

  localparam int unsigned RB = ANGLE_BITS - 2;
  localparam logic [RB-1:0] SPAN = RB'(1) << (ANGLE_BITS - 3);

  logic [ANGLE_BITS-1:0] ang;
  logic [2:0]            k_d;
  logic [RB-1:0]         r_low, r_d, r_q;
  logic [2:0]            k0_q, k1_q, k2_q, k3_q, k4_q;
  logic [63:0]           x, x2, x3_q, x4_q;

  logic [63:0]  st [0:TAYLOR_STEPS];
  logic [63:0]  ct [0:TAYLOR_STEPS];
  aarm_carry_t  cy [0:TAYLOR_STEPS];

  logic [63:0] ssf_q, csf_q, ssr, csr, sm_q, cm_q;
  logic [2:0]  kf_q, km_q, kp1;
  logic signed [63:0] s_q, c_q;

  // octant and offset; odd octants run backwards
  assign ang   = ANGLE_BITS'(angle_i);
  assign k_d   = ang[ANGLE_BITS-1 -: 3];
  assign r_low = RB'(ang[ANGLE_BITS-4:0]);
  assign r_d   = k_d[0] ? (SPAN - r_low) : r_low;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q  <= r_d;
      k0_q <= k_d;
    end
    if (en_i[1]) k1_q <= k0_q;
    if (en_i[2]) k2_q <= k1_q;
    if (en_i[3]) begin
      k3_q <= k2_q;
      x3_q <= x;
    end
    if (en_i[4]) begin
      k4_q <= k3_q;
      x4_q <= x3_q;
    end
  end

  aarm_mul #(.SHIFT(ANGLE_BITS - 3), .ROUND(1'b1)) u_mul_x (
    .clk_i(clk_i), .en_i(en_i[2:1]), .a_i(64'(r_q)), .b_i(PI4_Q62), .p_o(x));
  aarm_mul #(.SHIFT(62), .ROUND(1'b1)) u_mul_x2 (
    .clk_i(clk_i), .en_i(en_i[4:3]), .a_i(x), .b_i(x), .p_o(x2));

  assign st[0] = x4_q;
  assign ct[0] = ONE_Q62;
  assign cy[0] = '{ss: x4_q, cs: ONE_Q62, x2: x2, k: k4_q};

  for (genvar j = 1; j <= TAYLOR_STEPS; j++) begin : g_step
    aarm_step #(.J(j)) u_step (
      .clk_i  (clk_i),
      .en_i   (en_i[STEP_BASE + STEP_STAGES * (j - 1) +: STEP_STAGES]),
      .st_i   (st[j-1]),
      .ct_i   (ct[j-1]),
      .carry_i(cy[j-1]),
      .st_o   (st[j]),
      .ct_o   (ct[j]),
      .carry_o(cy[j])
    );
  end

  // last term is odd: subtract
  assign ssr = (ssf_q + 64'd1) >> 1;
  assign csr = (csf_q + 64'd1) >> 1;
  assign kp1 = kf_q + 3'd1;

  always_ff @(posedge clk_i) begin
    if (en_i[FIN_BASE]) begin
      ssf_q <= cy[TAYLOR_STEPS].ss - st[TAYLOR_STEPS];
      csf_q <= cy[TAYLOR_STEPS].cs - ct[TAYLOR_STEPS];
      kf_q  <= cy[TAYLOR_STEPS].k;
    end
    if (en_i[FIN_BASE+1]) begin
      sm_q <= kp1[1] ? csr : ssr;
      cm_q <= kp1[1] ? ssr : csr;
      km_q <= kf_q;
    end
    if (en_i[FIN_BASE+2]) begin
      s_q <= km_q[2] ? -$signed(sm_q) : $signed(sm_q);
      c_q <= (km_q[2] ^ km_q[1]) ? -$signed(cm_q) : $signed(cm_q);
    end
  end

  assign s_o = s_q;
  assign c_o = c_q;

endmodule

@@ hdl/axis_angle_rotation_matrix.sv @@
// Pipeline: 80 register stages, from the stage that accepts a request to the
//   output register that holds its matrix.
// Throughput: one request per cycle unless the output is stalled with every
//   stage full; unrolled 13-step series, each step with its own pipelined 64-bit multipliers.
// Reset: rst_ni clears only the stage valid bits; datapath registers are not reset.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Rodrigues rotation matrix R = cI + (1-c)uu^T + s[u]x from an axis in Q1.30
// and a binary angle, entries saturated to +-1.0, row-major.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
  parameter int unsigned FRAC_BITS  = aarm_pkg::AARM_FRAC_BITS,
  parameter int unsigned ANGLE_BITS = aarm_pkg::AARM_ANGLE_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] axis_x_i,
  input  logic signed [31:0] axis_y_i,
  input  logic signed [31:0] axis_z_i,
  input  logic        [31:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] m00_o,
  output logic signed [31:0] m01_o,
  output logic signed [31:0] m02_o,
  output logic signed [31:0] m10_o,
  output logic signed [31:0] m11_o,
  output logic signed [31:0] m12_o,
  output logic signed [31:0] m20_o,
  output logic signed [31:0] m21_o,
  output logic signed [31:0] m22_o
);
  import aarm_pkg::*;

  localparam int unsigned STAGES = TRIG_STAGES + MAT_STAGES;
  localparam int unsigned M      = TRIG_STAGES;
  // rounding shift that takes the Q61 cosine to the output format
  localparam int unsigned CF_SH  = (FRAC_BITS > 61) ? 0 : 61 - FRAC_BITS;
  localparam logic signed [63:0] LIM  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] NLIM = -LIM;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } axis_t;

  logic [STAGES-1:0] en;

  // --------------------------------------------------------------------------
  // Pipeline control: valid bits per stage, enables collapse bubbles so new
  // requests keep entering while a result is held at the output.
  // --------------------------------------------------------------------------
  aarm_pipe_ctl #(.STAGES(STAGES)) u_ctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .stall_o(in_stall_o),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .en_o   (en)
  );

  // --------------------------------------------------------------------------
  // Cosine and sine, Q61
  // --------------------------------------------------------------------------
  logic signed [63:0] c, s;

  aarm_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig (
    .clk_i  (clk_i),
    .en_i   (en[TRIG_STAGES-1:0]),
    .angle_i(angle_i),
    .c_o    (c),
    .s_o    (s)
  );

  // Axis rides alongside the trig pipe
  axis_t ax_q [0:TRIG_STAGES-1];

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_ax
    if (i == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (en[0]) ax_q[0] <= '{x: axis_x_i, y: axis_y_i, z: axis_z_i};
      end
    end else begin : g_tap
      always_ff @(posedge clk_i) begin
        if (en[i]) ax_q[i] <= ax_q[i-1];
      end
    end
  end

  axis_t ax;
  assign ax = ax_q[TRIG_STAGES-1];

  // --------------------------------------------------------------------------
  // Matrix stage 0: 1-c, magnitudes, axis outer products
  // Order of p: xx, xy, xz, yy, yz, zz
  // --------------------------------------------------------------------------
  logic [63:0]        omc_q0, cmag_q0, smag_q0;
  logic               cneg_q0, sneg_q0;
  logic signed [63:0] p_q0 [0:5];
  logic [31:0]        umag_q0 [0:2];
  logic               uneg_q0 [0:2];
  logic signed [31:0] ucomp [0:2];

  assign ucomp[0] = ax.x;
  assign ucomp[1] = ax.y;
  assign ucomp[2] = ax.z;

  always_ff @(posedge clk_i) begin
    if (en[M]) begin
      omc_q0  <= ONE_Q61 - c;
      cmag_q0 <= c[63] ? 64'(-c) : 64'(c);
      cneg_q0 <= c[63];
      smag_q0 <= s[63] ? 64'(-s) : 64'(s);
      sneg_q0 <= s[63];
      p_q0[0] <= 64'(ax.x) * 64'(ax.x);
      p_q0[1] <= 64'(ax.x) * 64'(ax.y);
      p_q0[2] <= 64'(ax.x) * 64'(ax.z);
      p_q0[3] <= 64'(ax.y) * 64'(ax.y);
      p_q0[4] <= 64'(ax.y) * 64'(ax.z);
      p_q0[5] <= 64'(ax.z) * 64'(ax.z);
      for (int i = 0; i < 3; i++) begin
        umag_q0[i] <= ucomp[i][31] ? 32'(-ucomp[i]) : 32'(ucomp[i]);
        uneg_q0[i] <= ucomp[i][31];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Matrix stage 1: product magnitudes, cosine rounded to output format
  // --------------------------------------------------------------------------
  logic [63:0] cfmag_d;

  if (FRAC_BITS > 61) begin : g_cf_wide
    assign cfmag_d = cmag_q0 << 1;
  end else if (CF_SH == 0) begin : g_cf_same
    assign cfmag_d = cmag_q0;
  end else begin : g_cf_round
    assign cfmag_d = (cmag_q0 + (64'd1 << (CF_SH - 1))) >> CF_SH;
  end

  logic [63:0] pmag_q1 [0:5];
  logic        pneg_q1 [0:5];
  logic [63:0] omc_q1, smag_q1, cfmag_q1;
  logic [31:0] umag_q1 [0:2];
  logic        vneg_q1 [0:2];
  logic        cneg_q1;

  always_ff @(posedge clk_i) begin
    if (en[M+1]) begin
      for (int i = 0; i < 6; i++) begin
        pmag_q1[i] <= p_q0[i][63] ? 64'(-p_q0[i]) : 64'(p_q0[i]);
        pneg_q1[i] <= p_q0[i][63];
      end
      for (int i = 0; i < 3; i++) begin
        umag_q1[i] <= umag_q0[i];
        vneg_q1[i] <= uneg_q0[i] ^ sneg_q0;
      end
      omc_q1   <= omc_q0;
      smag_q1  <= smag_q0;
      cfmag_q1 <= cfmag_d;
      cneg_q1  <= cneg_q0;
    end
  end

  // --------------------------------------------------------------------------
  // Matrix stages 2-3: (1-c)*u_i*u_j and s*u_k, rounded, in magnitude form
  // --------------------------------------------------------------------------
  logic [63:0] tmag [0:5];
  logic [63:0] vmag [0:2];

  for (genvar i = 0; i < 6; i++) begin : g_tmul
    aarm_mul #(.SHIFT(FRAC_BITS + 61), .ROUND(1'b1)) u_mul_t (
      .clk_i(clk_i), .en_i(en[M+3:M+2]), .a_i(pmag_q1[i]), .b_i(omc_q1),
      .p_o(tmag[i]));
  end

  for (genvar i = 0; i < 3; i++) begin : g_vmul
    aarm_mul #(.SHIFT(61), .ROUND(1'b1)) u_mul_v (
      .clk_i(clk_i), .en_i(en[M+3:M+2]), .a_i(64'(umag_q1[i])), .b_i(smag_q1),
      .p_o(vmag[i]));
  end

  logic               pneg_q2 [0:5];
  logic               pneg_q3 [0:5];
  logic               vneg_q2 [0:2];
  logic               vneg_q3 [0:2];
  logic signed [63:0] cf_q2, cf_q3;

  always_ff @(posedge clk_i) begin
    if (en[M+2]) begin
      pneg_q2 <= pneg_q1;
      vneg_q2 <= vneg_q1;
      cf_q2   <= cneg_q1 ? -$signed(cfmag_q1) : $signed(cfmag_q1);
    end
    if (en[M+3]) begin
      pneg_q3 <= pneg_q2;
      vneg_q3 <= vneg_q2;
      cf_q3   <= cf_q2;
    end
  end

  // --------------------------------------------------------------------------
  // Matrix stage 4: restore signs
  // --------------------------------------------------------------------------
  logic signed [63:0] t_q4 [0:5];
  logic signed [63:0] v_q4 [0:2];
  logic signed [63:0] cf_q4;

  always_ff @(posedge clk_i) begin
    if (en[M+4]) begin
      for (int i = 0; i < 6; i++) begin
        t_q4[i] <= pneg_q3[i] ? -$signed(tmag[i]) : $signed(tmag[i]);
      end
      for (int i = 0; i < 3; i++) begin
        v_q4[i] <= vneg_q3[i] ? -$signed(vmag[i]) : $signed(vmag[i]);
      end
      cf_q4 <= cf_q3;
    end
  end

  // --------------------------------------------------------------------------
  // Matrix stage 5: the nine entries, row-major
  // --------------------------------------------------------------------------
  logic signed [63:0] e_q5 [0:8];

  always_ff @(posedge clk_i) begin
    if (en[M+5]) begin
      e_q5[0] <= cf_q4   + t_q4[0];
      e_q5[1] <= t_q4[1] - v_q4[2];
      e_q5[2] <= t_q4[2] + v_q4[1];
      e_q5[3] <= t_q4[1] + v_q4[2];
      e_q5[4] <= cf_q4   + t_q4[3];
      e_q5[5] <= t_q4[4] - v_q4[0];
      e_q5[6] <= t_q4[2] - v_q4[1];
      e_q5[7] <= t_q4[4] + v_q4[0];
      e_q5[8] <= cf_q4   + t_q4[5];
    end
  end

  // --------------------------------------------------------------------------
  // Matrix stage 6: saturate to +-1.0, output register
  // --------------------------------------------------------------------------
  logic [31:0] out_q [0:8];

  always_ff @(posedge clk_i) begin
    if (en[M+6]) begin
      for (int i = 0; i < 9; i++) begin
        if (e_q5[i] > LIM) begin
          out_q[i] <= LIM[31:0];
        end else if (e_q5[i] < NLIM) begin
          out_q[i] <= NLIM[31:0];
        end else begin
          out_q[i] <= e_q5[i][31:0];
        end
      end
    end
  end

  assign m00_o = out_q[0];
  assign m01_o = out_q[1];
  assign m02_o = out_q[2];
  assign m10_o = out_q[3];
  assign m11_o = out_q[4];
  assign m12_o = out_q[5];
  assign m20_o = out_q[6];
  assign m21_o = out_q[7];
  assign m22_o = out_q[8];

endmodule

@@ sim/tb_axis_angle_rotation_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_axis_angle_rotation_matrix
// Self-checking bench for the Rodrigues rotation matrix pipeline. An exact
// integer model of the series sine/cosine and entry rounding predicts every
// matrix. Directed corner requests come first, then random bursts, a long
// output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_axis_angle_rotation_matrix;
  import aarm_pkg::*;

  typedef logic [8:0][31:0] matrix_t;

  localparam int unsigned SH_ENTRY  = AARM_FRAC_BITS + 61;
  localparam int unsigned SH_ANGLE  = AARM_ANGLE_BITS - 3;
  localparam int          LATENCY   = 80;
  localparam longint      CYCLE_CAP = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] axis_x_i = '0;
  logic signed [31:0] axis_y_i = '0;
  logic signed [31:0] axis_z_i = '0;
  logic        [31:0] angle_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;

  matrix_t matrices_due[$];
  int      errors = 0;
  int      requests_sent = 0;
  int      matrices_seen = 0;
  longint  cycle_count = 0;
  int      hold_off_len = 0;   // set by a test, counted down by the stall process
  int      stall_mode = 0;

  axis_angle_rotation_matrix DUT (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .axis_x_i, .axis_y_i, .axis_z_i, .angle_i,
    .out_valid_o, .out_stall_i,
    .m00_o, .m01_o, .m02_o, .m10_o, .m11_o, .m12_o, .m20_o, .m21_o, .m22_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Run limit: well beyond the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("%0t timeout with %0d matrices outstanding", $time, matrices_due.size());
      $display("tb_axis_angle_rotation_matrix: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Exact model of the datapath
  // ---------------------------------------------------------------------------

  // round(a*b / 2^sh), ties up, unsigned; 128-bit wrap as in the datapath
  function automatic logic [63:0] round_mul_u(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    if (sh > 0) prod = prod + (128'd1 << (sh - 1));
    return 64'(prod >> sh);
  endfunction

  // signed round, ties away from zero
  function automatic longint round_mul_s(longint a, longint b, int sh);
    logic [63:0] ua, ub, r;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    r  = round_mul_u(ua, ub, sh);
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [31:0] clamp_entry(longint v);
    longint lim;
    lim = longint'(1) << AARM_FRAC_BITS;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[31:0];
  endfunction

  // cosine and sine in Q61 from a binary angle, octant folded series
  task automatic octant_trig(input logic [31:0] ang, output longint cos_q61,
                             output longint sin_q61);
    logic [63:0] span, r, x, x2, st, ct, ss, cs, t;
    int k;
    k    = int'(ang[31:29]);
    span = 64'd1 << SH_ANGLE;
    r    = {35'd0, ang[28:0]};
    if (k[0]) r = span - r;
    x  = round_mul_u(r, PI4_Q62, SH_ANGLE);
    x2 = round_mul_u(x, x, 62);
    st = x; ss = x; ct = ONE_Q62; cs = ONE_Q62;
    for (int j = 1; j <= TAYLOR_STEPS; j++) begin
      st = round_mul_u(st, x2, 62) / 64'((2 * j) * (2 * j + 1));
      ct = round_mul_u(ct, x2, 62) / 64'((2 * j - 1) * (2 * j));
      if (j % 2) begin
        ss = ss - st; cs = cs - ct;
      end else begin
        ss = ss + st; cs = cs + ct;
      end
    end
    ss = (ss + 64'd1) >> 1;
    cs = (cs + 64'd1) >> 1;
    if (((k + 1) >> 1) % 2) begin
      t = ss; ss = cs; cs = t;
    end
    sin_q61 = (k >= 4) ? -longint'(ss) : longint'(ss);
    cos_q61 = (k >= 2 && k <= 5) ? -longint'(cs) : longint'(cs);
  endtask

  task automatic predict_rotation(input logic signed [31:0] ax, ay, az,
                                  input logic [31:0] ang, output matrix_t m);
    longint ux, uy, uz, c, s, omc, cf, vx, vy, vz;
    longint t00, t01, t02, t11, t12, t22;
    ux = ax; uy = ay; uz = az;
    octant_trig(ang, c, s);
    omc = longint'(ONE_Q61) - c;
    cf  = round_mul_s(c, 1, 61 - AARM_FRAC_BITS);
    t00 = round_mul_s(ux * ux, omc, SH_ENTRY);
    t01 = round_mul_s(ux * uy, omc, SH_ENTRY);
    t02 = round_mul_s(ux * uz, omc, SH_ENTRY);
    t11 = round_mul_s(uy * uy, omc, SH_ENTRY);
    t12 = round_mul_s(uy * uz, omc, SH_ENTRY);
    t22 = round_mul_s(uz * uz, omc, SH_ENTRY);
    vx  = round_mul_s(ux, s, 61);
    vy  = round_mul_s(uy, s, 61);
    vz  = round_mul_s(uz, s, 61);
    m[0] = clamp_entry(cf + t00);
    m[1] = clamp_entry(t01 - vz);
    m[2] = clamp_entry(t02 + vy);
    m[3] = clamp_entry(t01 + vz);
    m[4] = clamp_entry(cf + t11);
    m[5] = clamp_entry(t12 - vx);
    m[6] = clamp_entry(t02 - vy);
    m[7] = clamp_entry(t12 + vx);
    m[8] = clamp_entry(cf + t22);
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until taken; valid stays high afterwards so
  // back-to-back requests need no lowering.
  task automatic send_request(input logic signed [31:0] ax, ay, az, input logic [31:0] ang);
    matrix_t m;
    in_valid_i <= 1'b1;
    axis_x_i   <= ax;
    axis_y_i   <= ay;
    axis_z_i   <= az;
    angle_i    <= ang;
    do @(posedge clk_i); while (in_stall_o);
    predict_rotation(ax, ay, az, ang, m);
    matrices_due.push_back(m);
    requests_sent++;
  endtask

  task automatic idle_input(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_axis();
    // mostly within +-1.0, sometimes any raw value so every bit toggles
    if ($urandom_range(7) == 0) return $urandom;
    return $signed($urandom_range(32'h8000_0000, 0)) - 32'sh4000_0000;
  endfunction

  // random axes and angles in bursts of random length with random gaps
  task automatic send_random(input int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(40, 1);
      if (burst > left) burst = left;
      repeat (burst) send_request(rand_axis(), rand_axis(), rand_axis(), $urandom);
      left -= burst;
      if ($urandom_range(3) != 0) idle_input($urandom_range(6, 1));
    end
    in_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Stall pattern changes every so often; a requested hold-off overrides it
  always @(posedge clk_i) begin
    if (hold_off_len > 0) begin
      hold_off_len <= hold_off_len - 1;
      out_stall_i  <= 1'b1;
    end else begin
      if ($urandom_range(63) == 0) stall_mode <= $urandom_range(3);
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(3) == 0);
        2:       out_stall_i <= ($urandom_range(3) != 0);
        default: out_stall_i <= 1'($urandom_range(1));
      endcase
    end
  end

  always @(posedge clk_i) begin
    matrix_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {m22_o, m21_o, m20_o, m12_o, m11_o, m10_o, m02_o, m01_o, m00_o};
      matrices_seen++;
      if (matrices_due.size() == 0) begin
        $display("%0t unexpected matrix, m00=%h", $time, m00_o);
        errors++;
      end else begin
        want = matrices_due.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== want[i]) begin
            $display("%0t m%0d%0d mismatch: expected %h actual %h",
                     $time, i / 3, i % 3, want[i], got[i]);
            errors++;
          end
      end
    end
  end

  task automatic wait_drained();
    while (matrices_due.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Octant edges, extreme axes, zero and non-unit axes
  task automatic test_directed();
    localparam logic signed [31:0] ONE = 32'sh4000_0000;
    send_request(ONE, 0, 0, 32'h0000_0000);
    send_request(0, ONE, 0, 32'h2000_0000);
    send_request(0, 0, ONE, 32'h4000_0000);
    send_request(-ONE, 0, 0, 32'h6000_0000);
    send_request(0, -ONE, 0, 32'h8000_0000);
    send_request(0, 0, -ONE, 32'hA000_0000);
    send_request(ONE, ONE, ONE, 32'hC000_0000);       // non-unit axis, saturates
    send_request(-ONE, -ONE, -ONE, 32'hE000_0000);
    send_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF);
    send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h1FFF_FFFF);
    send_request(0, 0, 0, 32'h3456_789A);             // zero axis
    send_request(32'sh24F3_4E8B, 32'sh24F3_4E8B, 32'sh24F3_4E8B, 32'h1555_5555);
    send_request(ONE, 0, 0, 32'h0000_0001);
    send_request(0, ONE, 0, 32'h5FFF_FFFF);
    send_request(0, 0, ONE, 32'h9FFF_FFFF);
    send_request(32'sh2D41_3CCD, -32'sh2D41_3CCD, 0, 32'hDFFF_FFFF);
    send_request(-ONE, ONE, -ONE, 32'hAAAA_AAAA);
    send_request(ONE, -ONE, ONE, 32'h5555_5555);
    idle_input(1);
    wait_drained();
  endtask

  task automatic test_random_bursts();
    send_random(1300);
  endtask

  // Output held off for a long stretch while requests keep coming
  task automatic test_backpressure();
    hold_off_len = 300;
    send_random(150);
  endtask

  // Sender waits for every matrix, then resumes
  task automatic test_drain_pause();
    wait_drained();
    send_random(50);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_bursts();
    test_backpressure();
    test_drain_pause();
    wait_drained();
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("Covered %0d requests (octant edges, extreme and zero axes, random bursts,",
             requests_sent);
    $display("  long output hold-off, drain pause); %0d matrices checked", matrices_seen);
    if (errors == 0 && matrices_due.size() == 0)
      $display("tb_axis_angle_rotation_matrix: clean");
    else
      $display("tb_axis_angle_rotation_matrix: errors");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/aarm_pkg.sv
hdl/aarm_pipe_ctl.sv
hdl/aarm_mul.sv
hdl/aarm_step.sv
hdl/aarm_trig.sv
hdl/axis_angle_rotation_matrix.sv
sim/tb_axis_angle_rotation_matrix.sv
